/* rtl/core/pnst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnst_pkg: shared types and constants of the paired node slot table
// Request kinds, request/response structs, table size and fill values.
// ----------------------------------------------------------------------------
package pnst_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam logic [7:0]        BATTERY_ON_ADD = 8'd100;
  localparam logic signed [7:0] SIGNAL_ON_ADD  = -8'sd127;
  localparam logic [31:0]       TIMEOUT_RESET  = 32'd60000;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_REPORT = 2'd2,
    REQ_LOOKUP = 2'd3
  } req_kind_t;

  typedef struct packed {
    req_kind_t          kind;
    logic [47:0]        node_address;
    logic [5:0]         slot_index;
    logic [7:0]         node_kind;
    logic [15:0]        seq_number;
    logic [7:0]         battery_level;
    logic signed [7:0]  signal_strength;
    logic [31:0]        now_ms;
  } req_t;

  typedef struct packed {
    logic               accepted;
    logic [5:0]         match_slot;
    logic               free_found;
    logic [5:0]         free_slot;
    logic [6:0]         paired_total;
    logic [6:0]         online_total;
    logic [7:0]         read_kind;
    logic [15:0]        read_seq;
    logic [7:0]         read_battery;
    logic signed [7:0]  read_signal;
    logic               read_paired;
    logic               read_online;
  } rsp_t;

endpackage

/* rtl/core/pnst_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnst_table: slot storage and single-pass request logic
// Applies one request to the slot state and forms the response from the
// updated state; the state is written when commit is high.
// ----------------------------------------------------------------------------
module pnst_table import pnst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        commit,
  input  req_t        req,
  input  logic [31:0] timeout,
  output rsp_t        rsp
);

  logic [SLOT_COUNT-1:0] paired;
  logic [SLOT_COUNT-1:0] online;
  logic [47:0]           address   [SLOT_COUNT];
  logic [7:0]            kind      [SLOT_COUNT];
  logic [15:0]           seq       [SLOT_COUNT];
  logic [7:0]            battery   [SLOT_COUNT];
  logic signed [7:0]     signal    [SLOT_COUNT];
  logic [31:0]           seen_at   [SLOT_COUNT];

  logic [SLOT_COUNT-1:0] paired_next;
  logic [SLOT_COUNT-1:0] online_next;
  logic [47:0]           address_next   [SLOT_COUNT];
  logic [7:0]            kind_next      [SLOT_COUNT];
  logic [15:0]           seq_next       [SLOT_COUNT];
  logic [7:0]            battery_next   [SLOT_COUNT];
  logic signed [7:0]     signal_next    [SLOT_COUNT];
  logic [31:0]           seen_at_next   [SLOT_COUNT];

  logic                  in_range;
  logic [SLOT_W-1:0]     idx;
  logic [SLOT_COUNT-1:0] pre_match;
  logic [SLOT_COUNT-1:0] post_match;
  logic [SLOT_COUNT-1:0] live;
  logic [31:0]           age [SLOT_COUNT];
  logic                  add_ok;
  logic                  rem_ok;
  logic                  rpt_ok;

  assign in_range = {1'b0, req.slot_index} < 7'(SLOT_COUNT);
  assign idx      = req.slot_index[SLOT_W-1:0];

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      pre_match[i] = paired[i] && (address[i] == req.node_address);
    end
  end

  assign add_ok = (req.kind == REQ_ADD) && in_range && !(|pre_match);
  assign rem_ok = (req.kind == REQ_REMOVE) && in_range && paired[idx];
  assign rpt_ok = (req.kind == REQ_REPORT) && in_range && paired[idx];

  always_comb begin
    paired_next    = paired;
    online_next    = online;
    address_next   = address;
    kind_next      = kind;
    seq_next       = seq;
    battery_next   = battery;
    signal_next    = signal;
    seen_at_next   = seen_at;
    post_match     = pre_match;
    if (add_ok) begin
      paired_next[idx]    = 1'b1;
      online_next[idx]    = 1'b0;
      address_next[idx]   = req.node_address;
      kind_next[idx]      = req.node_kind;
      seq_next[idx]       = '0;
      battery_next[idx]   = BATTERY_ON_ADD;
      signal_next[idx]    = SIGNAL_ON_ADD;
      seen_at_next[idx]   = '0;
      post_match          = '0;
      post_match[idx]     = 1'b1;
    end
    if (rem_ok) begin
      paired_next[idx]    = 1'b0;
      online_next[idx]    = 1'b0;
      address_next[idx]   = '0;
      kind_next[idx]      = '0;
      seq_next[idx]       = '0;
      battery_next[idx]   = '0;
      signal_next[idx]    = '0;
      seen_at_next[idx]   = '0;
      post_match[idx]     = 1'b0;
    end
    if (rpt_ok) begin
      online_next[idx]    = 1'b1;
      seq_next[idx]       = req.seq_number;
      battery_next[idx]   = req.battery_level;
      signal_next[idx]    = req.signal_strength;
      seen_at_next[idx]   = req.now_ms;
    end
  end

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      age[i]  = req.now_ms - seen_at_next[i];
      live[i] = paired_next[i] && online_next[i] && (age[i] < timeout);
    end
  end

  always_comb begin
    rsp = '0;
    unique case (req.kind)
      REQ_ADD:    rsp.accepted = add_ok;
      REQ_REMOVE: rsp.accepted = rem_ok;
      REQ_REPORT: rsp.accepted = rpt_ok;
      REQ_LOOKUP: rsp.accepted = |post_match;
      default:    rsp.accepted = 1'b0;
    endcase
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (post_match[i]) begin
        rsp.match_slot = 6'(i);
      end
      if (!paired_next[i]) begin
        rsp.free_found = 1'b1;
        rsp.free_slot  = 6'(i);
      end
    end
    for (int i = 0; i < SLOT_COUNT; i++) begin
      rsp.paired_total = rsp.paired_total + 7'(paired_next[i]);
      rsp.online_total = rsp.online_total + 7'(live[i]);
    end
    if (in_range) begin
      rsp.read_kind    = kind_next[idx];
      rsp.read_seq     = seq_next[idx];
      rsp.read_battery = battery_next[idx];
      rsp.read_signal  = signal_next[idx];
      rsp.read_paired  = paired_next[idx];
      rsp.read_online  = online_next[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      paired <= '0;
      online <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        address[i]   <= '0;
        kind[i]      <= '0;
        seq[i]       <= '0;
        battery[i]   <= '0;
        signal[i]    <= '0;
        seen_at[i]   <= '0;
      end
    end else if (commit) begin
      paired    <= paired_next;
      online    <= online_next;
      address   <= address_next;
      kind      <= kind_next;
      seq       <= seq_next;
      battery   <= battery_next;
      signal    <= signal_next;
      seen_at   <= seen_at_next;
    end
  end

  a_unique_address: assert property (@(posedge clk) disable iff (rst)
    $onehot0(pre_match))
    else $error("address paired in more than one slot");

  a_online_paired: assert property (@(posedge clk) disable iff (rst)
    (online & ~paired) == '0)
    else $error("online slot not paired");

  a_count_commit: assert property (@(posedge clk) disable iff (rst)
    commit |=> $countones(paired) == 32'($past(rsp.paired_total)))
    else $error("paired count differs from stored marks");

  a_add_marks: assert property (@(posedge clk) disable iff (rst)
    commit && add_ok |=> paired[$past(idx)] && !online[$past(idx)])
    else $error("add did not pair slot offline");

  a_remove_clears: assert property (@(posedge clk) disable iff (rst)
    commit && rem_ok |=> !paired[$past(idx)] && !online[$past(idx)])
    else $error("remove left slot marked");

endmodule

/* rtl/core/paired_node_slot_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paired_node_slot_table: table of paired nodes keyed by 48-bit address
// Takes add, remove, report and lookup requests and returns one response
// per request with counts, free slot, match and slot readback.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  in        in_valid / in_stall   req_type .. now_ms
//  out       out_valid / out_stall accepted .. read_online
//  cfg       cfg_valid / cfg_ready online_timeout_ms
//
//  One item per cycle while the output is not stalled; an item waits in
//  the input register, where the table logic evaluates it, then sits in
//  the output register; out_valid is registered and set on advance.
//  Synchronous reset clears the table and sets the timeout to 60000.
//  A stalled output holds one item and one more waits in the input register.
// ----------------------------------------------------------------------------
module paired_node_slot_table import pnst_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic [47:0]        node_address,
  input  logic [5:0]         slot_index,
  input  logic [7:0]         node_kind,
  input  logic [15:0]        seq_number,
  input  logic [7:0]         battery_level,
  input  logic signed [7:0]  signal_strength,
  input  logic [31:0]        now_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               accepted,
  output logic [5:0]         match_slot,
  output logic               free_found,
  output logic [5:0]         free_slot,
  output logic [6:0]         paired_total,
  output logic [6:0]         online_total,
  output logic [7:0]         read_kind,
  output logic [15:0]        read_seq,
  output logic [7:0]         read_battery,
  output logic signed [7:0]  read_signal,
  output logic               read_paired,
  output logic               read_online,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        online_timeout_ms
);

  logic        s1_valid;
  req_t        s1_req;
  rsp_t        rsp_next;
  rsp_t        rsp;
  logic [31:0] timeout;
  logic        advance;
  logic        take_in;

  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;
  assign take_in   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout <= online_timeout_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take_in) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_req.kind            <= req_kind_t'(req_type);
      s1_req.node_address    <= node_address;
      s1_req.slot_index      <= slot_index;
      s1_req.node_kind       <= node_kind;
      s1_req.seq_number      <= seq_number;
      s1_req.battery_level   <= battery_level;
      s1_req.signal_strength <= signal_strength;
      s1_req.now_ms          <= now_ms;
    end
  end

  pnst_table u_table (
    .clk     (clk),
    .rst     (rst),
    .commit  (advance),
    .req     (s1_req),
    .timeout (timeout),
    .rsp     (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= rsp_next;
    end
  end

  assign accepted     = rsp.accepted;
  assign match_slot   = rsp.match_slot;
  assign free_found   = rsp.free_found;
  assign free_slot    = rsp.free_slot;
  assign paired_total = rsp.paired_total;
  assign online_total = rsp.online_total;
  assign read_kind    = rsp.read_kind;
  assign read_seq     = rsp.read_seq;
  assign read_battery = rsp.read_battery;
  assign read_signal  = rsp.read_signal;
  assign read_paired  = rsp.read_paired;
  assign read_online  = rsp.read_online;

  a_hold_output: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rsp))
    else $error("stalled item lost");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_req))
    else $error("waiting item overwritten");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("evaluated item not registered");

endmodule
